// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define CTL_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error(msg);

// Clocked assertion on the local clk and rst_n.
`define CTL_ASSERT(lbl, prop, msg) \
    `CTL_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

// File: rtl/ctl_pkg.sv
// Types and constants for the cursor tuple list.
`timescale 1ns / 1ps

package ctl_pkg;

    localparam int WORD_W      = 32;
    localparam int TUPLE_WORDS = 5;
    localparam int TUPLE_W     = WORD_W * TUPLE_WORDS;
    localparam int KIND_W      = 4;

    typedef logic [TUPLE_W-1:0] tuple_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR       = 4'd0,
        KIND_INSERT      = 4'd1,
        KIND_REMOVE      = 4'd2,
        KIND_SWAP_NEXT   = 4'd3,
        KIND_SWAP_PREV   = 4'd4,
        KIND_CURSOR_NEXT = 4'd5,
        KIND_CURSOR_PREV = 4'd6,
        KIND_READ        = 4'd7,
        KIND_WRITE       = 4'd8,
        KIND_SEARCH      = 4'd9
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_DRAIN,
        ST_PUT,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_SWAP_C,
        ST_SWAP_D,
        ST_RD_A,
        ST_RD_B,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_DONE
    } ctl_state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

// File: rtl/ctl_if.sv
// Request and result channel interfaces of the cursor tuple list.
`timescale 1ns / 1ps

interface ctl_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [ctl_pkg::KIND_W-1:0]   kind;
    logic [ctl_pkg::WORD_W-1:0]   word_0;
    logic [ctl_pkg::WORD_W-1:0]   word_1;
    logic [ctl_pkg::WORD_W-1:0]   word_2;
    logic [ctl_pkg::WORD_W-1:0]   word_3;
    logic [ctl_pkg::WORD_W-1:0]   word_4;

    modport source (output valid, kind, word_0, word_1, word_2, word_3, word_4,
                    input ready);
    modport sink   (input valid, kind, word_0, word_1, word_2, word_3, word_4,
                    output ready);
endinterface

interface ctl_res_if #(parameter int CNT_W = 7);
    logic                         valid;
    logic                         ready;
    logic [CNT_W-1:0]             length;
    logic [CNT_W-1:0]             cursor;
    logic [ctl_pkg::WORD_W-1:0]   out_0;
    logic [ctl_pkg::WORD_W-1:0]   out_1;
    logic [ctl_pkg::WORD_W-1:0]   out_2;
    logic [ctl_pkg::WORD_W-1:0]   out_3;
    logic [ctl_pkg::WORD_W-1:0]   out_4;
    logic                         found;
    logic                         status;

    modport source (output valid, length, cursor, out_0, out_1, out_2, out_3, out_4,
                    found, status, input ready);
    modport sink   (input valid, length, cursor, out_0, out_1, out_2, out_3, out_4,
                    found, status, output ready);
endinterface

// File: rtl/cursor_tuple_list_core.sv
// Top level of the cursor tuple list: command sequencer around the tuple store.
`timescale 1ns / 1ps
//
// Ordered list of up to LIST_DEPTH five-word tuples with a cursor.
// cmd (sink): one request per command, taken when valid and ready are high.
// res (source): exactly one result per request, in request order.
// ready is high only while the sequencer is idle; a request then runs alone.
// Clear, cursor moves, ignored commands and a search of an empty list go
// straight to the done state; a write puts the tuple, a read passes two read
// states, a swap four swap states and a search scans every entry. An insert
// shifts the entries above its position up and then puts, or only puts when
// appending; a remove shifts the entries behind the cursor down, or only
// drops the last entry. Shifts and searches stream through the store's single
// read port, one entry a cycle; a shift overlaps the write of the previous entry.
// The result sits in an output register; the next request is taken while
// it waits, and a stalled receiver holds the sequencer in its final state
// only once a second result is ready.
// Reset clears length, cursor and the channel state; the store needs no
// clearing, since no command reads beyond the entries it has written.

module cursor_tuple_list_core #(
    parameter int LIST_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    ctl_cmd_if.sink          cmd,
    ctl_res_if.source        res
);

    localparam int AW    = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int WW    = ctl_pkg::WORD_W;

    ctl_pkg::ctl_state_t state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    cursor_reg, cursor_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic [AW-1:0]       other_reg, other_next;
    logic                grow_reg, grow_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       pend_addr_reg, pend_addr_next;
    logic                cmp_reg, cmp_next;
    ctl_pkg::tuple_t     tuple_reg, tuple_next;
    ctl_pkg::tuple_t     tmp_reg, tmp_next;
    logic                res_status_reg, res_status_next;
    logic                res_found_reg, res_found_next;
    ctl_pkg::tuple_t     res_rd_reg, res_rd_next;
    logic                out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]    out_len_reg, out_len_next;
    logic [CNT_W-1:0]    out_cur_reg, out_cur_next;
    ctl_pkg::tuple_t     out_rd_reg, out_rd_next;
    logic                out_found_reg, out_found_next;
    logic                out_status_reg, out_status_next;

    ctl_pkg::mem_ctl_t   mem_ctl;
    logic [AW-1:0]       wr_addr;
    ctl_pkg::tuple_t     wr_data;
    logic [AW-1:0]       rd_addr;
    ctl_pkg::tuple_t     rd_data;

    logic                cmd_fire;
    logic                out_free;
    ctl_pkg::kind_t      in_kind;
    logic [CNT_W:0]      cur_w, cnt_w, ins_base;
    logic [CNT_W-1:0]    ins_pos;
    logic [CNT_W-1:0]    idx_dec, idx_inc;
    logic                full, cur_past, next_past, cur_zero;
    logic                shift_last, scan_last;

    ctl_store #(.DEPTH(LIST_DEPTH)) u_store (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // handshake, range checks against the current length and cursor, index steps
    always_comb
    begin
        cmd_fire   = cmd.valid && cmd.ready;
        out_free   = !out_valid_reg || res.ready;
        in_kind    = ctl_pkg::kind_t'(cmd.kind);
        cur_w      = {1'b0, cursor_reg};
        cnt_w      = {1'b0, count_reg};
        full       = (count_reg == CNT_W'(LIST_DEPTH));
        cur_past   = (cur_w >= cnt_w);
        next_past  = ((cur_w + (CNT_W+1)'(1)) >= cnt_w);
        cur_zero   = (cursor_reg == '0);
        ins_base   = cur_w + ((count_reg != '0) ? (CNT_W+1)'(1) : (CNT_W+1)'(0));
        ins_pos    = (ins_base > cnt_w) ? count_reg : ins_base[CNT_W-1:0];
        idx_dec    = idx_reg - CNT_W'(1);
        idx_inc    = idx_reg + CNT_W'(1);
        shift_last = grow_reg ? (idx_reg == pos_reg + CNT_W'(1))
                              : (({1'b0, idx_reg} + (CNT_W+1)'(2)) == cnt_w);
        scan_last  = (({1'b0, idx_reg} + (CNT_W+1)'(1)) == cnt_w);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ctl_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (in_kind)
                        ctl_pkg::KIND_INSERT:
                            state_next = full ? ctl_pkg::ST_DONE :
                                         (count_reg > ins_pos) ? ctl_pkg::ST_SHIFT :
                                         ctl_pkg::ST_PUT;
                        ctl_pkg::KIND_REMOVE:
                            state_next = (cur_past || next_past) ? ctl_pkg::ST_DONE
                                                                 : ctl_pkg::ST_SHIFT;
                        ctl_pkg::KIND_SWAP_NEXT:
                            state_next = next_past ? ctl_pkg::ST_DONE : ctl_pkg::ST_SWAP_A;
                        ctl_pkg::KIND_SWAP_PREV:
                            state_next = (cur_zero || cur_past) ? ctl_pkg::ST_DONE
                                                                : ctl_pkg::ST_SWAP_A;
                        ctl_pkg::KIND_READ:
                            state_next = cur_past ? ctl_pkg::ST_DONE : ctl_pkg::ST_RD_A;
                        ctl_pkg::KIND_WRITE:
                            state_next = cur_past ? ctl_pkg::ST_DONE : ctl_pkg::ST_PUT;
                        ctl_pkg::KIND_SEARCH:
                            state_next = (count_reg == '0) ? ctl_pkg::ST_DONE
                                                           : ctl_pkg::ST_SCAN;
                        default:
                            state_next = ctl_pkg::ST_DONE;
                    endcase
                end
            end
            ctl_pkg::ST_SHIFT:
            begin
                if (shift_last)
                begin
                    state_next = ctl_pkg::ST_DRAIN;
                end
            end
            ctl_pkg::ST_DRAIN:     state_next = grow_reg ? ctl_pkg::ST_PUT : ctl_pkg::ST_DONE;
            ctl_pkg::ST_PUT:       state_next = ctl_pkg::ST_DONE;
            ctl_pkg::ST_SWAP_A:    state_next = ctl_pkg::ST_SWAP_B;
            ctl_pkg::ST_SWAP_B:    state_next = ctl_pkg::ST_SWAP_C;
            ctl_pkg::ST_SWAP_C:    state_next = ctl_pkg::ST_SWAP_D;
            ctl_pkg::ST_SWAP_D:    state_next = ctl_pkg::ST_DONE;
            ctl_pkg::ST_RD_A:      state_next = ctl_pkg::ST_RD_B;
            ctl_pkg::ST_RD_B:      state_next = ctl_pkg::ST_DONE;
            ctl_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ctl_pkg::ST_SCAN_LAST;
                end
            end
            ctl_pkg::ST_SCAN_LAST: state_next = ctl_pkg::ST_DONE;
            ctl_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ctl_pkg::ST_IDLE;
                end
            end
            default:               state_next = ctl_pkg::ST_IDLE;
        endcase
    end

    // datapath and store control
    always_comb
    begin
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        other_next      = other_reg;
        grow_next       = grow_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        cmp_next        = 1'b0;
        tuple_next      = tuple_reg;
        tmp_next        = tmp_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_rd_next     = res_rd_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_len_next    = out_len_reg;
        out_cur_next    = out_cur_reg;
        out_rd_next     = out_rd_reg;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        mem_ctl         = '0;
        wr_addr         = pend_addr_reg;
        wr_data         = rd_data;
        rd_addr         = cursor_reg[AW-1:0];

        // overlapped write-back of the entry read last cycle
        if (pend_reg)
        begin
            mem_ctl.wr_en = 1'b1;
        end
        if (cmp_reg && (rd_data == tuple_reg))
        begin
            res_found_next = 1'b1;
        end

        unique case (state_reg)
            ctl_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    tuple_next      = {cmd.word_4, cmd.word_3, cmd.word_2,
                                       cmd.word_1, cmd.word_0};
                    res_status_next = 1'b0;
                    res_found_next  = 1'b0;
                    res_rd_next     = '0;
                    grow_next       = 1'b0;
                    unique case (in_kind)
                        ctl_pkg::KIND_CLEAR:
                        begin
                            count_next  = '0;
                            cursor_next = '0;
                        end
                        ctl_pkg::KIND_INSERT:
                        begin
                            if (full)
                            begin
                                res_status_next = 1'b1;
                            end
                            else
                            begin
                                pos_next  = ins_pos;
                                grow_next = 1'b1;
                                idx_next  = count_reg;
                            end
                        end
                        ctl_pkg::KIND_REMOVE:
                        begin
                            if (cur_past)
                            begin
                                res_status_next = 1'b1;
                            end
                            else if (next_past)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                idx_next = cursor_reg;
                            end
                        end
                        ctl_pkg::KIND_SWAP_NEXT:
                        begin
                            if (next_past)
                            begin
                                res_status_next = 1'b1;
                            end
                            other_next = AW'(cursor_reg + CNT_W'(1));
                        end
                        ctl_pkg::KIND_SWAP_PREV:
                        begin
                            if (cur_zero || cur_past)
                            begin
                                res_status_next = 1'b1;
                            end
                            other_next = AW'(cursor_reg - CNT_W'(1));
                        end
                        ctl_pkg::KIND_CURSOR_NEXT:
                        begin
                            if (next_past)
                            begin
                                res_status_next = 1'b1;
                            end
                            else
                            begin
                                cursor_next = cursor_reg + CNT_W'(1);
                            end
                        end
                        ctl_pkg::KIND_CURSOR_PREV:
                        begin
                            if (cur_zero)
                            begin
                                res_status_next = 1'b1;
                            end
                            else
                            begin
                                cursor_next = cursor_reg - CNT_W'(1);
                            end
                        end
                        ctl_pkg::KIND_READ:
                        begin
                            res_status_next = cur_past;
                        end
                        ctl_pkg::KIND_WRITE:
                        begin
                            res_status_next = cur_past;
                            pos_next        = cursor_reg;
                        end
                        ctl_pkg::KIND_SEARCH:
                        begin
                            idx_next = '0;
                        end
                        default:
                        begin
                            res_status_next = 1'b1;
                        end
                    endcase
                end
            end
            ctl_pkg::ST_SHIFT:
            begin
                mem_ctl.rd_en  = 1'b1;
                rd_addr        = grow_reg ? idx_dec[AW-1:0] : idx_inc[AW-1:0];
                pend_next      = 1'b1;
                pend_addr_next = idx_reg[AW-1:0];
                idx_next       = grow_reg ? idx_dec : idx_inc;
            end
            ctl_pkg::ST_DRAIN:
            begin
                if (!grow_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ctl_pkg::ST_PUT:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = pos_reg[AW-1:0];
                wr_data       = tuple_reg;
                if (grow_reg)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ctl_pkg::ST_SWAP_A:
            begin
                mem_ctl.rd_en = 1'b1;
            end
            ctl_pkg::ST_SWAP_B:
            begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = other_reg;
                tmp_next      = rd_data;
            end
            ctl_pkg::ST_SWAP_C:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = cursor_reg[AW-1:0];
            end
            ctl_pkg::ST_SWAP_D:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = other_reg;
                wr_data       = tmp_reg;
            end
            ctl_pkg::ST_RD_A:
            begin
                mem_ctl.rd_en = 1'b1;
            end
            ctl_pkg::ST_RD_B:
            begin
                res_rd_next = rd_data;
            end
            ctl_pkg::ST_SCAN:
            begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = idx_reg[AW-1:0];
                cmp_next      = 1'b1;
                idx_next      = idx_inc;
            end
            ctl_pkg::ST_SCAN_LAST:
            begin
            end
            ctl_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_len_next    = count_reg;
                    out_cur_next    = cursor_reg;
                    out_rd_next     = res_rd_reg;
                    out_found_next  = res_found_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ctl_pkg::ST_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            pend_reg      <= 1'b0;
            cmp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            pend_reg      <= pend_next;
            cmp_reg       <= cmp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        other_reg      <= other_next;
        grow_reg       <= grow_next;
        pend_addr_reg  <= pend_addr_next;
        tuple_reg      <= tuple_next;
        tmp_reg        <= tmp_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_rd_reg     <= res_rd_next;
        out_len_reg    <= out_len_next;
        out_cur_reg    <= out_cur_next;
        out_rd_reg     <= out_rd_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
    end

    assign cmd.ready  = (state_reg == ctl_pkg::ST_IDLE);
    assign res.valid  = out_valid_reg;
    assign res.length = out_len_reg;
    assign res.cursor = out_cur_reg;
    assign res.out_0  = out_rd_reg[0*WW +: WW];
    assign res.out_1  = out_rd_reg[1*WW +: WW];
    assign res.out_2  = out_rd_reg[2*WW +: WW];
    assign res.out_3  = out_rd_reg[3*WW +: WW];
    assign res.out_4  = out_rd_reg[4*WW +: WW];
    assign res.found  = out_found_reg;
    assign res.status = out_status_reg;

endmodule

// File: rtl/ctl_store.sv
// Tuple store: one write port, one registered read port.
`timescale 1ns / 1ps

module ctl_store #(
    parameter int  DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  ctl_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]     wr_addr,
    input  ctl_pkg::tuple_t   wr_data,
    input  logic [AW-1:0]     rd_addr,
    output ctl_pkg::tuple_t   rd_data
);

    ctl_pkg::tuple_t mem_reg [DEPTH];
    ctl_pkg::tuple_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/ctl_checker.sv
// Port-level checker for the cursor tuple list and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ctl_checker #(
    parameter int LIST_DEPTH = 64,
    parameter int CNT_W      = 7
) (
    input logic             clk,
    input logic             rst_n,
    input logic             cmd_valid,
    input logic             cmd_ready,
    input logic             res_valid,
    input logic             res_ready,
    input logic [CNT_W-1:0] res_length,
    input logic [CNT_W-1:0] res_cursor,
    input logic             res_found,
    input logic             res_status
);

    `CTL_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid, "result dropped while stalled")
    `CTL_ASSERT(a_busy_after_req, cmd_valid && cmd_ready |=> !cmd_ready, "request taken while busy")
    `CTL_ASSERT(a_len_range, res_valid |-> res_length <= CNT_W'(LIST_DEPTH), "length beyond depth")
    `CTL_ASSERT(a_cur_range, res_valid |-> res_cursor <= res_length, "cursor beyond length")
    `CTL_ASSERT(a_found_done, res_valid && res_found |-> !res_status, "found on ignored request")

endmodule

bind cursor_tuple_list_core ctl_checker #(
    .LIST_DEPTH (LIST_DEPTH),
    .CNT_W      (CNT_W)
) u_ctl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_length (res.length),
    .res_cursor (res.cursor),
    .res_found  (res.found),
    .res_status (res.status)
);
